FILE: src/tkst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k score table package
// Field widths, item codes, defaults and controller/datapath link types.
// ----------------------------------------------------------------------------
package tkst_pkg;

    localparam int FUNC_W  = 2;
    localparam int LEVEL_W = 2;
    localparam int SCORE_W = 24;
    localparam int TAG_W   = 24;
    localparam int RANK_W  = 4;
    localparam int POS_W   = 4;

    localparam int DEF_RANKS     = 10;
    localparam int DEF_LEVELS    = 3;
    localparam int DEF_NAME_BITS = 24;

    localparam logic [TAG_W-1:0] DASH_TAG = 24'h2D2D2D;

    localparam logic [FUNC_W-1:0] FN_CHECK  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_LOAD   = 2'd3;

    typedef struct packed {
        logic latch;
        logic rd_last;
        logic rd_prev;
        logic rd_rank;
        logic eval_last;
        logic shift;
        logic place;
        logic load_wr;
        logic eval_read;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              lvl_ok;
        logic              rank_ok;
        logic              beats;
        logic              j_one;
        logic              out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

FILE: src/tkst_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one table item.
// ----------------------------------------------------------------------------
interface tkst_req_if;
    import tkst_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [LEVEL_W-1:0] level;
    logic [SCORE_W-1:0] new_score;
    logic [TAG_W-1:0]   name_tag;
    logic [RANK_W-1:0]  rank;

    modport source (output valid, output func, output level, output new_score,
                    output name_tag, output rank, input ready);
    modport sink   (input valid, input func, input level, input new_score,
                    input name_tag, input rank, output ready);
endinterface
`default_nettype wire

FILE: src/tkst_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface tkst_rsp_if;
    import tkst_pkg::*;

    logic               valid;
    logic               ready;
    logic               qualifies;
    logic [POS_W-1:0]   position;
    logic [SCORE_W-1:0] entry_score;
    logic [TAG_W-1:0]   entry_name;

    modport source (output valid, output qualifies, output position,
                    output entry_score, output entry_name, input ready);
    modport sink   (input valid, input qualifies, input position,
                    input entry_score, input entry_name, output ready);
endinterface
`default_nettype wire

FILE: src/tkst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k score table controller
// Sequences one item at a time: dispatch, last-entry compare, bottom-up
// scan with shift, placement, read and load, then result hand-off.
// ----------------------------------------------------------------------------
module tkst_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    tkst_req_if.sink               i_in,
    input  wire tkst_pkg::t_dp_sts i_sts,
    output tkst_pkg::t_dp_cmd      o_cmd
);
    import tkst_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_LAST_EV  = 3'd2;
    localparam logic [2:0] ST_SCAN_RD  = 3'd3;
    localparam logic [2:0] ST_SCAN_EV  = 3'd4;
    localparam logic [2:0] ST_PLACE    = 3'd5;
    localparam logic [2:0] ST_DATA_EV  = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign i_in.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_state = ST_DONE;
                if (i_sts.func inside {FN_CHECK, FN_INSERT}) begin
                    if (i_sts.lvl_ok) begin
                        o_cmd.rd_last = 1'b1;
                        n_state       = ST_LAST_EV;
                    end
                end else if (i_sts.func == FN_READ) begin
                    if (i_sts.lvl_ok && i_sts.rank_ok) begin
                        o_cmd.rd_rank = 1'b1;
                        n_state       = ST_DATA_EV;
                    end
                end else begin
                    o_cmd.load_wr = i_sts.lvl_ok && i_sts.rank_ok;
                end
            end
            ST_LAST_EV: begin
                o_cmd.eval_last = 1'b1;
                if (i_sts.func == FN_INSERT && i_sts.beats) begin
                    n_state = ST_SCAN_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN_RD: begin
                o_cmd.rd_prev = 1'b1;
                n_state       = ST_SCAN_EV;
            end
            ST_SCAN_EV: begin
                if (i_sts.beats) begin
                    o_cmd.shift = 1'b1;
                    n_state     = i_sts.j_one ? ST_PLACE : ST_SCAN_RD;
                end else begin
                    n_state = ST_PLACE;
                end
            end
            ST_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DATA_EV: begin
                o_cmd.eval_read = 1'b1;
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

FILE: src/tkst_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k score table datapath
// Entry memory with per-entry valid bits, item registers, scan index,
// compare and the result register.
// ----------------------------------------------------------------------------
module tkst_dp #(
    parameter int RANKS     = tkst_pkg::DEF_RANKS,
    parameter int LEVELS    = tkst_pkg::DEF_LEVELS,
    parameter int NAME_BITS = tkst_pkg::DEF_NAME_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [tkst_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [tkst_pkg::LEVEL_W-1:0]   i_level,
    input  wire logic [tkst_pkg::SCORE_W-1:0]   i_new_score,
    input  wire logic [tkst_pkg::TAG_W-1:0]     i_name_tag,
    input  wire logic [tkst_pkg::RANK_W-1:0]    i_rank,
    input  wire tkst_pkg::t_dp_cmd              i_cmd,
    output tkst_pkg::t_dp_sts                   o_sts,
    tkst_rsp_if.source                          o_out
);
    import tkst_pkg::*;

    localparam int DEPTH = LEVELS * RANKS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(RANKS);
    localparam int PW    = $clog2(RANKS + 1);

    logic [SCORE_W-1:0]   mem_score [DEPTH];
    logic [NAME_BITS-1:0] mem_name  [DEPTH];
    logic [DEPTH-1:0]     r_valid;

    logic [FUNC_W-1:0]    r_func;
    logic                 r_lvl_ok;
    logic                 r_rank_ok;
    logic [SCORE_W-1:0]   r_score;
    logic [NAME_BITS-1:0] r_tag;
    logic [RANK_W-1:0]    r_rank;
    logic [AW-1:0]        r_base;
    logic [RW-1:0]        r_j;

    logic [SCORE_W-1:0]   r_rd_score;
    logic [NAME_BITS-1:0] r_rd_name;
    logic                 r_rd_vld;

    logic                 r_q;
    logic [PW-1:0]        r_pos;
    logic [SCORE_W-1:0]   r_esc;
    logic [TAG_W-1:0]     r_enm;

    logic                 r_out_valid;
    logic                 r_o_q;
    logic [POS_W-1:0]     r_o_pos;
    logic [SCORE_W-1:0]   r_o_esc;
    logic [TAG_W-1:0]     r_o_enm;

    logic [AW-1:0]        rd_addr;
    logic                 rd_en;
    logic [AW-1:0]        wr_addr;
    logic                 wr_en;
    logic [SCORE_W-1:0]   wr_score;
    logic [NAME_BITS-1:0] wr_name;
    logic [SCORE_W-1:0]   eff_score;
    logic [NAME_BITS-1:0] eff_name;

    assign eff_score = r_rd_vld ? r_rd_score : '0;
    assign eff_name  = r_rd_vld ? r_rd_name : NAME_BITS'(DASH_TAG);

    always_comb begin
        rd_en = i_cmd.rd_last | i_cmd.rd_prev | i_cmd.rd_rank;
        if (i_cmd.rd_last) begin
            rd_addr = r_base + AW'(RANKS - 1);
        end else if (i_cmd.rd_prev) begin
            rd_addr = r_base + AW'(r_j) - AW'(1);
        end else begin
            rd_addr = r_base + AW'(r_rank);
        end
    end

    always_comb begin
        wr_en    = i_cmd.shift | i_cmd.place | i_cmd.load_wr;
        wr_score = r_score;
        wr_name  = r_tag;
        if (i_cmd.load_wr) begin
            wr_addr = r_base + AW'(r_rank);
        end else begin
            wr_addr = r_base + AW'(r_j);
        end
        if (i_cmd.shift) begin
            wr_score = eff_score;
            wr_name  = eff_name;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_score[wr_addr] <= wr_score;
            mem_name[wr_addr]  <= wr_name;
        end
        if (rd_en) begin
            r_rd_score <= mem_score[rd_addr];
            r_rd_name  <= mem_name[rd_addr];
            r_rd_vld   <= r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func    <= i_func;
            r_lvl_ok  <= int'(i_level) < LEVELS;
            r_rank_ok <= int'(i_rank) < RANKS;
            r_score   <= i_new_score;
            r_tag     <= NAME_BITS'(i_name_tag);
            r_rank    <= i_rank;
            r_base    <= AW'(int'(i_level) * RANKS);
            r_j       <= RW'(RANKS - 1);
            r_q       <= 1'b0;
            r_pos     <= PW'(RANKS);
            r_esc     <= '0;
            r_enm     <= '0;
        end else begin
            if (i_cmd.eval_last) begin
                r_q <= r_score > eff_score;
            end
            if (i_cmd.shift) begin
                r_j <= r_j - RW'(1);
            end
            if (i_cmd.place) begin
                r_pos <= PW'(r_j);
            end
            if (i_cmd.eval_read) begin
                r_esc <= eff_score;
                r_enm <= TAG_W'(eff_name);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_q   <= r_q;
            r_o_pos <= POS_W'(r_pos);
            r_o_esc <= r_esc;
            r_o_enm <= r_enm;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.qualifies   = r_o_q;
    assign o_out.position    = r_o_pos;
    assign o_out.entry_score = r_o_esc;
    assign o_out.entry_name  = r_o_enm;

    assign o_sts.func     = r_func;
    assign o_sts.lvl_ok   = r_lvl_ok;
    assign o_sts.rank_ok  = r_rank_ok;
    assign o_sts.beats    = r_score > eff_score;
    assign o_sts.j_one    = (r_j == RW'(1));
    assign o_sts.out_free = !r_out_valid || o_out.ready;
endmodule
`default_nettype wire

FILE: src/top_k_sorted_score_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k sorted score table
// Per-level descending score/name tables with check, insert, read and load.
// ----------------------------------------------------------------------------
// Check and read pass dispatch and an evaluate state; load and out-of-range
// items go from dispatch to the result. An insert scans bottom-up, reading,
// comparing and shifting one entry at a time via the entry memory's single
// read and write port. One item at a time: the next is taken the cycle after
// the result is loaded. Reset clears control state and entry valid bits at once;
// unwritten entries read as score zero and the dash tag, with no clearing pass.
module top_k_sorted_score_table #(
    parameter int RANKS     = tkst_pkg::DEF_RANKS,
    parameter int LEVELS    = tkst_pkg::DEF_LEVELS,
    parameter int NAME_BITS = tkst_pkg::DEF_NAME_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tkst_req_if.sink   i_in,
    tkst_rsp_if.source o_out
);
    import tkst_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    tkst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tkst_dp #(
        .RANKS     (RANKS),
        .LEVELS    (LEVELS),
        .NAME_BITS (NAME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_func      (i_in.func),
        .i_level     (i_in.level),
        .i_new_score (i_in.new_score),
        .i_name_tag  (i_in.name_tag),
        .i_rank      (i_in.rank),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out       (o_out)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("item accepted while another is in progress");

    a_landed_qualified: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.position != POS_W'(RANKS) |-> o_out.qualifies)
        else $error("insert landed without qualifying");

    a_read_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.entry_score != '0 || o_out.entry_name != '0)
        |-> !o_out.qualifies && o_out.position == POS_W'(RANKS))
        else $error("entry data on a non-read result");
endmodule
`default_nettype wire
